// ----- sv/langevin_rk4_step_core_defines.svh -----
// Assertion macros for the Langevin RK4 step core.
// Included by the modules that carry concurrent checks; depends on nothing else.
`ifndef LANGEVIN_RK4_STEP_CORE_DEFINES_SVH
`define LANGEVIN_RK4_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LRK_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lrk check failed");
`define LRK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrk check failed");
`define LRK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrk check failed");
`else
`define LRK_ASSERT_NEVER(label, clk, rst, cond)
`define LRK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LRK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/lrk_pkg.sv -----
// Shared types, constants and helper functions of the Langevin RK4 step core.
// No dependencies; every other file but the assertion macro header refers to it by scoped names.
`default_nettype none
package lrk_pkg;

  localparam int DATA_WIDTH = 48;
  localparam int FRAC_BITS  = 24;
  localparam int ACC_W      = 64;   // weighted stage sum and multiplier operands
  localparam int HALF_W     = ACC_W / 2;
  localparam int PROD_W     = 2 * ACC_W;
  localparam int ADDR_W     = 6;
  localparam int APB_W      = 64;

  localparam int STATE_N    = 8;
  localparam int KERNELS    = 4;
  localparam int LAST_STAGE = 3;

  // divide-by-six unit: DIV_BITS quotient bits per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_W      = ((DATA_WIDTH + 3 + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS  = DIV_W / DIV_BITS;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam logic [3:0] DIVISOR = 4'd6;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [PROD_W-1:0] LIM_POS  = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] LIM_NEG  = PROD_W'(1) << (DATA_WIDTH - 1);
  localparam logic [PROD_W-1:0] LIM6_POS = PROD_W'(6) * (LIM_POS + PROD_W'(1));
  localparam logic [PROD_W-1:0] LIM6_NEG = PROD_W'(6) * (LIM_NEG + PROD_W'(1));

  // register map
  localparam logic [2:0] REG_RATE_FIRST  = 3'd0;
  localparam logic [2:0] REG_RATE_SECOND = 3'd1;
  localparam logic [2:0] REG_COUP_FIRST  = 3'd2;
  localparam logic [2:0] REG_COUP_SECOND = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  typedef enum logic [2:0] {
    JOB_KPROD,
    JOB_KRATE,
    JOB_UPD,
    JOB_FIN,
    JOB_RX,
    JOB_RY
  } job_t;

  typedef struct packed {
    logic [31:0] rate_first_kernel;
    logic [31:0] rate_second_kernel;
    logic [39:0] coupling_first;
    logic [39:0] coupling_second;
    logic [24:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] noise_x_first;
    logic [DATA_WIDTH-1:0] noise_y_first;
    logic [DATA_WIDTH-1:0] noise_x_second;
    logic [DATA_WIDTH-1:0] noise_y_second;
  } noise_t;

  typedef struct packed {
    logic       load;
    logic       go;
    job_t       job;
    logic [2:0] idx;
    logic [1:0] stage;
    logic       lin;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_full;
  } dp_status_t;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             half_step;
    logic             div6;
  } scale_req_t;

  function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b,
      input logic                         sub);
    logic signed [DATA_WIDTH:0] s;
    if (sub) begin
      s = (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
    end else begin
      s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
    end
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
    end
    return $signed(s[DATA_WIDTH-1:0]);
  endfunction

endpackage
`default_nettype wire

// ----- sv/lrk_in_if.sv -----
// Input channel of the Langevin RK4 step core: one transaction carries four noise samples.
// Depends on lrk_pkg for the data width.
`default_nettype none
interface lrk_in_if;
  logic valid;
  logic ready;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] noise_x_first;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] noise_y_first;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] noise_x_second;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] noise_y_second;

  modport source (output valid, noise_x_first, noise_y_first, noise_x_second,
                  noise_y_second, input ready);
  modport sink (input valid, noise_x_first, noise_y_first, noise_x_second,
                noise_y_second, output ready);
endinterface
`default_nettype wire

// ----- sv/lrk_out_if.sv -----
// Output channel of the Langevin RK4 step core: positions, velocities and squared radius.
// Depends on lrk_pkg for the data width.
`default_nettype none
interface lrk_out_if;
  logic valid;
  logic ready;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] position_x;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] velocity_x;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] position_y;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] velocity_y;
  logic        [lrk_pkg::DATA_WIDTH-2:0] radius_squared;

  modport source (output valid, position_x, velocity_x, position_y, velocity_y,
                  radius_squared, input ready);
  modport sink (input valid, position_x, velocity_x, position_y, velocity_y,
                radius_squared, output ready);
endinterface
`default_nettype wire

// ----- sv/lrk_scale.sv -----
// Shared multi-cycle scaling multiplier: round(a*b / (div * 2^sh)), saturated to the data range.
// Depends on lrk_pkg and the assertion macro header.
`default_nettype none
`include "langevin_rk4_step_core_defines.svh"
module lrk_scale (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire lrk_pkg::scale_req_t                   req,
  output logic                                       done,
  output logic signed [lrk_pkg::DATA_WIDTH-1:0]      result
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_RND, S_CHK, S_DIV, S_FIN} st_t;

  st_t                               st;
  logic [lrk_pkg::ACC_W-1:0]         ua;
  logic [lrk_pkg::ACC_W-1:0]         ub;
  logic                              neg;
  logic                              half_step;
  logic                              div6;
  logic [1:0]                        cnt;
  logic [lrk_pkg::PROD_W-1:0]        acc;
  logic [lrk_pkg::PROD_W-1:0]        xs;
  logic [lrk_pkg::DIV_W-1:0]         dd;
  logic [2:0]                        rem;
  logic [lrk_pkg::DIV_W-1:0]         qacc;
  logic [lrk_pkg::DCNT_W-1:0]        dcnt;
  logic [lrk_pkg::DATA_WIDTH-1:0]    q;

  logic [lrk_pkg::HALF_W-1:0]        pa;
  logic [lrk_pkg::HALF_W-1:0]        pb;
  logic [2*lrk_pkg::HALF_W-1:0]      pp;
  logic [lrk_pkg::PROD_W-1:0]        pp_sh;
  logic [lrk_pkg::PROD_W-1:0]        rnd_half;
  logic [lrk_pkg::PROD_W-1:0]        rnd;
  logic [lrk_pkg::PROD_W-1:0]        xs_next;
  logic [lrk_pkg::PROD_W-1:0]        limit;
  logic [lrk_pkg::PROD_W-1:0]        limit6;
  logic [lrk_pkg::DIV_W-1:0]         dd_next;
  logic [2:0]                        rem_next;
  logic [lrk_pkg::DIV_W-1:0]         qacc_next;
  logic [3:0]                        nb;

  // one 32x32 partial product per cycle, lane chosen by cnt
  always_comb begin
    pa = cnt[1] ? ua[lrk_pkg::ACC_W-1:lrk_pkg::HALF_W] : ua[lrk_pkg::HALF_W-1:0];
    pb = cnt[0] ? ub[lrk_pkg::ACC_W-1:lrk_pkg::HALF_W] : ub[lrk_pkg::HALF_W-1:0];
    pp = pa * pb;
    case (cnt)
      2'b00:        pp_sh = lrk_pkg::PROD_W'(pp);
      2'b01, 2'b10: pp_sh = lrk_pkg::PROD_W'(pp) << lrk_pkg::HALF_W;
      default:      pp_sh = lrk_pkg::PROD_W'(pp) << (2 * lrk_pkg::HALF_W);
    endcase
  end

  always_comb begin
    if (div6) begin
      rnd_half = lrk_pkg::PROD_W'(3) << lrk_pkg::FRAC_BITS;
    end else if (half_step) begin
      rnd_half = lrk_pkg::PROD_W'(1) << lrk_pkg::FRAC_BITS;
    end else begin
      rnd_half = lrk_pkg::PROD_W'(1) << (lrk_pkg::FRAC_BITS - 1);
    end
    rnd     = acc + rnd_half;
    xs_next = half_step ? (rnd >> (lrk_pkg::FRAC_BITS + 1)) : (rnd >> lrk_pkg::FRAC_BITS);
    limit   = neg ? lrk_pkg::LIM_NEG : lrk_pkg::LIM_POS;
    limit6  = neg ? lrk_pkg::LIM6_NEG : lrk_pkg::LIM6_POS;
  end

  // restoring division by six, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_next  = rem;
    dd_next   = dd;
    qacc_next = qacc;
    nb        = '0;
    for (int k = 0; k < lrk_pkg::DIV_BITS; k++) begin
      nb      = {rem_next, dd_next[lrk_pkg::DIV_W-1]};
      dd_next = dd_next << 1;
      if (nb >= lrk_pkg::DIVISOR) begin
        rem_next  = 3'(nb - lrk_pkg::DIVISOR);
        qacc_next = {qacc_next[lrk_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_next  = nb[2:0];
        qacc_next = {qacc_next[lrk_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            ua        <= req.a[lrk_pkg::ACC_W-1] ? (~req.a + 1'b1) : req.a;
            ub        <= req.b[lrk_pkg::ACC_W-1] ? (~req.b + 1'b1) : req.b;
            neg       <= req.a[lrk_pkg::ACC_W-1] ^ req.b[lrk_pkg::ACC_W-1];
            half_step <= req.half_step;
            div6      <= req.div6;
            acc       <= '0;
            cnt       <= 2'd0;
            st        <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            st <= S_RND;
          end
        end
        S_RND: begin
          xs <= xs_next;
          st <= S_CHK;
        end
        S_CHK: begin
          if (div6) begin
            if (xs >= limit6) begin
              q  <= limit[lrk_pkg::DATA_WIDTH-1:0];
              st <= S_FIN;
            end else begin
              dd   <= xs[lrk_pkg::DIV_W-1:0];
              rem  <= 3'd0;
              qacc <= '0;
              dcnt <= '0;
              st   <= S_DIV;
            end
          end else begin
            q  <= (xs > limit) ? limit[lrk_pkg::DATA_WIDTH-1:0] : xs[lrk_pkg::DATA_WIDTH-1:0];
            st <= S_FIN;
          end
        end
        S_DIV: begin
          dd   <= dd_next;
          rem  <= rem_next;
          qacc <= qacc_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == lrk_pkg::DCNT_W'(lrk_pkg::DIV_STEPS - 1)) begin
            q  <= qacc_next[lrk_pkg::DATA_WIDTH-1:0];
            st <= S_FIN;
          end
        end
        S_FIN: begin
          result <= neg ? $signed(~q + 1'b1) : $signed(q);
          done   <= 1'b1;
          st     <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `LRK_ASSERT_NEVER(a_start_while_busy, clk, rst, start && (st != S_IDLE))
  `LRK_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `LRK_ASSERT_IMPLY(a_pos_in_range, clk, rst, done && !neg, !result[lrk_pkg::DATA_WIDTH-1])

endmodule
`default_nettype wire

// ----- sv/lrk_dpath.sv -----
// Datapath: state, stage vector, derivative and weighted-sum registers, scaling unit, output register.
// Depends on lrk_pkg, lrk_out_if and lrk_scale.
`default_nettype none
module lrk_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lrk_pkg::cfg_t        cfg,
  input  wire lrk_pkg::noise_t      noise_in,
  input  wire lrk_pkg::dp_cmd_t     cmd,
  output lrk_pkg::dp_status_t       status,
  lrk_out_if.source                 out_ch
);

  localparam int DW = lrk_pkg::DATA_WIDTH;
  localparam int AW = lrk_pkg::ACC_W;

  logic signed [DW-1:0]     v0    [lrk_pkg::STATE_N];
  logic signed [DW-1:0]     v1    [lrk_pkg::STATE_N];
  logic signed [DW-1:0]     kv    [lrk_pkg::STATE_N];
  logic signed [AW-1:0]     acc   [lrk_pkg::STATE_N];
  logic signed [DW-1:0]     noise [lrk_pkg::KERNELS];
  logic signed [DW-1:0]     tval;
  logic signed [DW-1:0]     rx;
  logic [DW-2:0]            rad;

  logic signed [DW-1:0]     knew  [lrk_pkg::STATE_N];
  logic signed [AW-1:0]     acc_new [lrk_pkg::STATE_N];
  lrk_pkg::scale_req_t      req;
  logic                     mul_done;
  logic signed [DW-1:0]     prod;
  logic [2:0]               mem_idx;
  logic [2:0]               vel_idx;
  logic signed [DW-1:0]     radius_sum;

  // kernel order: x first, y first, x second, y second
  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    mem_idx = 3'd2;
      2'd1:    mem_idx = 3'd5;
      2'd2:    mem_idx = 3'd6;
      default: mem_idx = 3'd7;
    endcase
    vel_idx = cmd.idx[0] ? 3'd4 : 3'd1;
  end

  always_comb begin
    req.a         = '0;
    req.b         = '0;
    req.half_step = 1'b0;
    req.div6      = 1'b0;
    case (cmd.job)
      lrk_pkg::JOB_KPROD: begin
        req.a = AW'(v1[vel_idx]);
        req.b = cmd.idx[1] ? AW'($signed(cfg.coupling_second))
                           : AW'($signed(cfg.coupling_first));
      end
      lrk_pkg::JOB_KRATE: begin
        req.a = cmd.idx[1] ? (AW'(0) - AW'(cfg.rate_second_kernel))
                           : (AW'(0) - AW'(cfg.rate_first_kernel));
        req.b = AW'(tval);
      end
      lrk_pkg::JOB_UPD: begin
        req.a         = AW'(cfg.time_step);
        req.b         = AW'(kv[cmd.idx]);
        req.half_step = !cmd.stage[1];
      end
      lrk_pkg::JOB_FIN: begin
        req.a    = AW'(cfg.time_step);
        req.b    = acc[cmd.idx];
        req.div6 = 1'b1;
      end
      lrk_pkg::JOB_RX: begin
        req.a = AW'(v0[0]);
        req.b = AW'(v0[0]);
      end
      lrk_pkg::JOB_RY: begin
        req.a = AW'(v0[3]);
        req.b = AW'(v0[3]);
      end
      default: begin
        req.a = '0;
      end
    endcase
  end

  lrk_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.go),
    .req    (req),
    .done   (mul_done),
    .result (prod)
  );

  // linear derivative terms, then fold the stage into the weighted sum
  always_comb begin
    for (int i = 0; i < lrk_pkg::STATE_N; i++) begin
      knew[i] = kv[i];
    end
    knew[0] = v1[1];
    knew[1] = lrk_pkg::sat_add(v1[2], v1[6], 1'b0);
    knew[3] = v1[4];
    knew[4] = lrk_pkg::sat_add(v1[5], v1[7], 1'b0);
    for (int i = 0; i < lrk_pkg::STATE_N; i++) begin
      if (cmd.stage == 2'd0) begin
        acc_new[i] = AW'(knew[i]);
      end else if (cmd.stage == 2'(lrk_pkg::LAST_STAGE)) begin
        acc_new[i] = acc[i] + AW'(knew[i]);
      end else begin
        acc_new[i] = acc[i] + (AW'(knew[i]) <<< 1);
      end
    end
  end

  assign radius_sum = lrk_pkg::sat_add(rx, prod, 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lrk_pkg::STATE_N; i++) begin
        v0[i] <= '0;
      end
      out_ch.valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < lrk_pkg::STATE_N; i++) begin
          v1[i] <= v0[i];
        end
        noise[0] <= $signed(noise_in.noise_x_first);
        noise[1] <= $signed(noise_in.noise_y_first);
        noise[2] <= $signed(noise_in.noise_x_second);
        noise[3] <= $signed(noise_in.noise_y_second);
      end
      if (cmd.lin) begin
        for (int i = 0; i < lrk_pkg::STATE_N; i++) begin
          kv[i]  <= knew[i];
          acc[i] <= acc_new[i];
        end
      end
      if (mul_done) begin
        case (cmd.job)
          lrk_pkg::JOB_KPROD: tval <= lrk_pkg::sat_add(
              lrk_pkg::sat_add(v1[mem_idx], prod, 1'b0), noise[cmd.idx[1:0]], 1'b1);
          lrk_pkg::JOB_KRATE: kv[mem_idx] <= prod;
          lrk_pkg::JOB_UPD:   v1[cmd.idx] <= lrk_pkg::sat_add(v0[cmd.idx], prod, 1'b0);
          lrk_pkg::JOB_FIN:   v0[cmd.idx] <= lrk_pkg::sat_add(v0[cmd.idx], prod, 1'b0);
          lrk_pkg::JOB_RX:    rx <= prod;
          lrk_pkg::JOB_RY:    rad <= radius_sum[DW-2:0];
          default:            rx <= rx;
        endcase
      end
      if (cmd.out_load) begin
        out_ch.valid          <= 1'b1;
        out_ch.position_x     <= v0[0];
        out_ch.velocity_x     <= v0[1];
        out_ch.position_y     <= v0[3];
        out_ch.velocity_y     <= v0[4];
        out_ch.radius_squared <= rad;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  assign status.mul_done = mul_done;
  assign status.out_full = out_ch.valid;

endmodule
`default_nettype wire

// ----- sv/lrk_ctrl.sv -----
// Controller: sequences the four RK4 stages, the final update and the radius on the datapath.
// Depends on lrk_pkg.
`default_nettype none
module lrk_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output lrk_pkg::dp_cmd_t          cmd,
  input  wire lrk_pkg::dp_status_t  status
);

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_LIN, ST_EMIT} st_t;

  st_t           st;
  lrk_pkg::job_t job;
  logic [2:0]    idx;
  logic [1:0]    stage;

  assign in_ready = (st == ST_IDLE);

  always_comb begin
    cmd.load     = (st == ST_IDLE) && in_valid;
    cmd.go       = (st == ST_ISSUE);
    cmd.job      = job;
    cmd.idx      = idx;
    cmd.stage    = stage;
    cmd.lin      = (st == ST_LIN);
    cmd.out_load = (st == ST_EMIT) && !status.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      job   <= lrk_pkg::JOB_KPROD;
      idx   <= 3'd0;
      stage <= 2'd0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            stage <= 2'd0;
            idx   <= 3'd0;
            job   <= lrk_pkg::JOB_KPROD;
            st    <= ST_ISSUE;
          end
        end
        ST_ISSUE: st <= ST_WAIT;
        ST_WAIT: begin
          if (status.mul_done) begin
            st <= ST_ISSUE;
            case (job)
              lrk_pkg::JOB_KPROD: job <= lrk_pkg::JOB_KRATE;
              lrk_pkg::JOB_KRATE: begin
                if (idx == 3'(lrk_pkg::KERNELS - 1)) begin
                  st <= ST_LIN;
                end else begin
                  idx <= idx + 3'd1;
                  job <= lrk_pkg::JOB_KPROD;
                end
              end
              lrk_pkg::JOB_UPD: begin
                if (idx == 3'(lrk_pkg::STATE_N - 1)) begin
                  stage <= stage + 2'd1;
                  idx   <= 3'd0;
                  job   <= lrk_pkg::JOB_KPROD;
                end else begin
                  idx <= idx + 3'd1;
                end
              end
              lrk_pkg::JOB_FIN: begin
                if (idx == 3'(lrk_pkg::STATE_N - 1)) begin
                  job <= lrk_pkg::JOB_RX;
                end else begin
                  idx <= idx + 3'd1;
                end
              end
              lrk_pkg::JOB_RX: job <= lrk_pkg::JOB_RY;
              lrk_pkg::JOB_RY: st <= ST_EMIT;
              default:         st <= ST_IDLE;
            endcase
          end
        end
        ST_LIN: begin
          idx <= 3'd0;
          job <= (stage == 2'(lrk_pkg::LAST_STAGE)) ? lrk_pkg::JOB_FIN : lrk_pkg::JOB_UPD;
          st  <= ST_ISSUE;
        end
        ST_EMIT: begin
          // hold until the previous result has left the output register
          if (!status.out_full) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/langevin_rk4_step_core.sv -----
// Langevin RK4 step core.
// in_ch (valid/ready) takes one transaction per time step: four Q23.24 noise samples.
// out_ch (valid/ready) returns one transaction per step: x/y position and velocity
// after the step and the saturated squared radius.
// Each step runs four derivative evaluations and the final update on one shared
// scaling multiplier (64x64 bits as four 32x32 partial products); the eight final
// updates also go through the divide by six, which those that saturate skip.
// The next item is accepted once the result is loaded.
// The result sits in an output register, so the core takes the next item while it
// waits; if the receiver still stalls when that next result is ready, the core holds.
// Reset (rst, synchronous) zeroes the eight state variables and loads the register
// defaults. Registers are written over the APB port at byte address 8*index;
// write only while the core is idle.
// Depends on lrk_pkg, lrk_in_if, lrk_out_if, lrk_ctrl and lrk_dpath.
`default_nettype none
module langevin_rk4_step_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lrk_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lrk_pkg::APB_W-1:0]    pwdata,
  output logic [lrk_pkg::APB_W-1:0]         prdata,
  output logic                              pready,
  lrk_in_if.sink                            in_ch,
  lrk_out_if.source                         out_ch
);

  lrk_pkg::cfg_t       cfg;
  lrk_pkg::noise_t     noise_in;
  lrk_pkg::dp_cmd_t    cmd;
  lrk_pkg::dp_status_t status;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_first_kernel  <= 32'd167772160;
      cfg.rate_second_kernel <= 32'd1677722;
      cfg.coupling_first     <= 40'd1694498816;
      cfg.coupling_second    <= -40'sd1677721600;
      cfg.time_step          <= 25'd16777;
    end else if (wr_en) begin
      case (reg_idx)
        lrk_pkg::REG_RATE_FIRST:  cfg.rate_first_kernel  <= pwdata[31:0];
        lrk_pkg::REG_RATE_SECOND: cfg.rate_second_kernel <= pwdata[31:0];
        lrk_pkg::REG_COUP_FIRST:  cfg.coupling_first     <= pwdata[39:0];
        lrk_pkg::REG_COUP_SECOND: cfg.coupling_second    <= pwdata[39:0];
        lrk_pkg::REG_TIME_STEP:   cfg.time_step          <= pwdata[24:0];
        default:                  cfg.time_step          <= cfg.time_step;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrk_pkg::REG_RATE_FIRST:  prdata = lrk_pkg::APB_W'(cfg.rate_first_kernel);
      lrk_pkg::REG_RATE_SECOND: prdata = lrk_pkg::APB_W'(cfg.rate_second_kernel);
      lrk_pkg::REG_COUP_FIRST:  prdata = lrk_pkg::APB_W'(cfg.coupling_first);
      lrk_pkg::REG_COUP_SECOND: prdata = lrk_pkg::APB_W'(cfg.coupling_second);
      lrk_pkg::REG_TIME_STEP:   prdata = lrk_pkg::APB_W'(cfg.time_step);
      default:                  prdata = '0;
    endcase
  end

  assign noise_in.noise_x_first  = in_ch.noise_x_first;
  assign noise_in.noise_y_first  = in_ch.noise_y_first;
  assign noise_in.noise_x_second = in_ch.noise_x_second;
  assign noise_in.noise_y_second = in_ch.noise_y_second;

  lrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  lrk_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .noise_in (noise_in),
    .cmd      (cmd),
    .status   (status),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ----- test/langevin_rk4_step_core_tb.sv -----
// Self-checking bench for the Langevin RK4 step core: random and directed noise steps
// against a bit-exact fixed-point predictor, with register changes between phases.
// Depends on lrk_pkg, lrk_in_if, lrk_out_if and langevin_rk4_step_core.
`default_nettype none

typedef struct {
  logic signed [lrk_pkg::DATA_WIDTH-1:0] position_x;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] velocity_x;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] position_y;
  logic signed [lrk_pkg::DATA_WIDTH-1:0] velocity_y;
  logic        [lrk_pkg::DATA_WIDTH-2:0] radius_squared;
} step_out_t;

class langevin_tracker;
  localparam longint D_MAX = (64'sd1 <<< (lrk_pkg::DATA_WIDTH - 1)) - 1;
  localparam longint D_MIN = -D_MAX - 1;
  localparam int FB = lrk_pkg::FRAC_BITS;

  lrk_pkg::cfg_t cfg;
  longint        st[8];
  step_out_t     expected_steps[$];
  int            errors;
  int            steps_checked;
  int            saturated_radius;

  function new();
    cfg.rate_first_kernel  = 32'd167772160;
    cfg.rate_second_kernel = 32'd1677722;
    cfg.coupling_first     = 40'd1694498816;
    cfg.coupling_second    = 40'(-64'sd1677721600);
    cfg.time_step          = 25'd16777;
    foreach (st[i]) st[i] = 0;
    errors = 0;
    steps_checked = 0;
    saturated_radius = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      lrk_pkg::REG_RATE_FIRST:  cfg.rate_first_kernel  = val[31:0];
      lrk_pkg::REG_RATE_SECOND: cfg.rate_second_kernel = val[31:0];
      lrk_pkg::REG_COUP_FIRST:  cfg.coupling_first     = val[39:0];
      lrk_pkg::REG_COUP_SECOND: cfg.coupling_second    = val[39:0];
      lrk_pkg::REG_TIME_STEP:   cfg.time_step          = val[24:0];
      default: ;
    endcase
  endfunction

  function longint clamp_data(longint a);
    return a > D_MAX ? D_MAX : (a < D_MIN ? D_MIN : a);
  endfunction

  function longint add_sat64(longint a, longint b, bit sub);
    logic signed [64:0] s;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    return s[63:0];
  endfunction

  function longint addd(longint a, longint b);
    return clamp_data(add_sat64(a, b, 1'b0));
  endfunction

  function longint subd(longint a, longint b);
    return clamp_data(add_sat64(a, b, 1'b1));
  endfunction

  // exact product, rounded half away from zero, divided, saturated
  function longint mul_scaled(longint a, longint b, int sh, int div);
    logic [129:0] ma, mb, p, lim;
    logic         neg;
    logic [63:0]  ua, ub;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    ma = {66'b0, ua};
    mb = {66'b0, ub};
    p = ma * mb;
    p = p + ((130'(div) << sh) >> 1);
    p = (p >> sh) / div;
    lim = neg ? (130'(1) << (lrk_pkg::DATA_WIDTH - 1))
              : ((130'(1) << (lrk_pkg::DATA_WIDTH - 1)) - 1);
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function longint kernel_rate(longint rneg, longint mem, longint vel, longint coup,
                               longint noise);
    longint t;
    t = subd(addd(mem, mul_scaled(vel, coup, FB, 1)), noise);
    return mul_scaled(rneg, t, FB, 1);
  endfunction

  function void derivative(input longint v[8], input longint n[4], output longint d[8]);
    longint r1, r2, g1, g2;
    r1 = -longint'({32'b0, cfg.rate_first_kernel});
    r2 = -longint'({32'b0, cfg.rate_second_kernel});
    g1 = longint'($signed(cfg.coupling_first));
    g2 = longint'($signed(cfg.coupling_second));
    d[2] = kernel_rate(r1, v[2], v[1], g1, n[0]);
    d[5] = kernel_rate(r1, v[5], v[4], g1, n[1]);
    d[6] = kernel_rate(r2, v[6], v[1], g2, n[2]);
    d[7] = kernel_rate(r2, v[7], v[4], g2, n[3]);
    d[0] = v[1];
    d[1] = addd(v[2], v[6]);
    d[3] = v[4];
    d[4] = addd(v[5], v[7]);
  endfunction

  function void note_noise(lrk_pkg::noise_t nz);
    longint n[4], v1[8], k0[8], k1[8], k2[8], k3[8], dt, s, rx, ry;
    step_out_t r;
    n[0] = longint'($signed(nz.noise_x_first));
    n[1] = longint'($signed(nz.noise_y_first));
    n[2] = longint'($signed(nz.noise_x_second));
    n[3] = longint'($signed(nz.noise_y_second));
    dt = longint'({39'b0, cfg.time_step});
    derivative(st, n, k0);
    foreach (v1[i]) v1[i] = addd(st[i], mul_scaled(dt, k0[i], FB + 1, 1));
    derivative(v1, n, k1);
    foreach (v1[i]) v1[i] = addd(st[i], mul_scaled(dt, k1[i], FB + 1, 1));
    derivative(v1, n, k2);
    foreach (v1[i]) v1[i] = addd(st[i], mul_scaled(dt, k2[i], FB, 1));
    derivative(v1, n, k3);
    foreach (st[i]) begin
      s = add_sat64(k0[i], k1[i], 1'b0);
      s = add_sat64(s, k1[i], 1'b0);
      s = add_sat64(s, k2[i], 1'b0);
      s = add_sat64(s, k2[i], 1'b0);
      s = add_sat64(s, k3[i], 1'b0);
      st[i] = addd(st[i], mul_scaled(dt, s, FB, 6));
    end
    rx = mul_scaled(st[0], st[0], FB, 1);
    ry = mul_scaled(st[3], st[3], FB, 1);
    r.position_x     = st[0];
    r.velocity_x     = st[1];
    r.position_y     = st[3];
    r.velocity_y     = st[4];
    r.radius_squared = addd(rx, ry);
    if (addd(rx, ry) == D_MAX) saturated_radius++;
    expected_steps.push_back(r);
  endfunction

  function void compare(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
    end
  endfunction

  function void check_step(step_out_t got);
    step_out_t e;
    if (expected_steps.size() == 0) begin
      errors++;
      $display("%0t unexpected result: position_x %h", $time, got.position_x);
      return;
    end
    e = expected_steps.pop_front();
    steps_checked++;
    compare("position_x", 64'(e.position_x), 64'(got.position_x));
    compare("velocity_x", 64'(e.velocity_x), 64'(got.velocity_x));
    compare("position_y", 64'(e.position_y), 64'(got.position_y));
    compare("velocity_y", 64'(e.velocity_y), 64'(got.velocity_y));
    compare("radius_squared", 64'(e.radius_squared), 64'(got.radius_squared));
  endfunction
endclass

module langevin_rk4_step_core_tb;

  localparam int  RANDOM_PHASES = 6;
  localparam int  PHASE_ITEMS   = 175;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lrk_pkg::ADDR_W-1:0]   paddr;
  logic [lrk_pkg::APB_W-1:0]    pwdata;
  logic [lrk_pkg::APB_W-1:0]    prdata;
  logic                         pready;

  lrk_in_if  in_ch();
  lrk_out_if out_ch();

  langevin_tracker tracker;
  int              send_pct;
  int              recv_pct;
  longint          cycles = 0;
  int              random_sent;

  langevin_rk4_step_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin
    step_out_t       got;
    lrk_pkg::noise_t nz;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end else if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        nz.noise_x_first  = in_ch.noise_x_first;
        nz.noise_y_first  = in_ch.noise_y_first;
        nz.noise_x_second = in_ch.noise_x_second;
        nz.noise_y_second = in_ch.noise_y_second;
        tracker.note_noise(nz);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.position_x     = out_ch.position_x;
        got.velocity_x     = out_ch.velocity_x;
        got.position_y     = out_ch.position_y;
        got.velocity_y     = out_ch.velocity_y;
        got.radius_squared = out_ch.radius_squared;
        tracker.check_step(got);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lrk_pkg::ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic load_config(logic [31:0] r1, logic [31:0] r2, logic [39:0] g1,
                             logic [39:0] g2, logic [24:0] dt);
    write_reg(lrk_pkg::REG_RATE_FIRST, 64'(r1));
    write_reg(lrk_pkg::REG_RATE_SECOND, 64'(r2));
    write_reg(lrk_pkg::REG_COUP_FIRST, 64'(g1));
    write_reg(lrk_pkg::REG_COUP_SECOND, 64'(g2));
    write_reg(lrk_pkg::REG_TIME_STEP, 64'(dt));
  endtask

  // hold until every step has come back, then let the datapath settle
  task automatic drain();
    while (tracker.expected_steps.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic send_step(logic [47:0] nxf, logic [47:0] nyf, logic [47:0] nxs,
                           logic [47:0] nys);
    // idle the sender cycle by cycle
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.noise_x_first  <= nxf;
    in_ch.noise_y_first  <= nyf;
    in_ch.noise_x_second <= nxs;
    in_ch.noise_y_second <= nys;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [47:0] pick_noise();
    int sel;
    int mag;
    sel = $urandom_range(9);
    mag = $urandom_range(14, 30);
    case (sel)
      0: return {16'($urandom), $urandom};
      1: begin
        case ($urandom_range(3))
          0: return 48'h7fff_ffff_ffff;
          1: return 48'h8000_0000_0000;
          2: return 48'h0;
          default: return 48'hffff_ffff_ffff;
        endcase
      end
      default: return 48'($signed({16'($urandom), $urandom}) >>> (47 - mag));
    endcase
  endfunction

  initial begin
    logic [47:0] pat [12][4];
    tracker     = new();
    random_sent = 0;
    send_pct    = 0;
    recv_pct    = 0;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.noise_x_first  <= '0;
    in_ch.noise_y_first  <= '0;
    in_ch.noise_x_second <= '0;
    in_ch.noise_y_second <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed steps under the reset settings: field extremes and bit patterns
    pat = '{
      '{48'h0, 48'h0, 48'h0, 48'h0},
      '{48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff},
      '{48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000},
      '{48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h7fff_ffff_ffff},
      '{48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa},
      '{48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555},
      '{48'hffff_ffff_ffff, 48'h1, 48'h1, 48'hffff_ffff_ffff},
      '{48'h100_0000, 48'hff_ff00_0000, 48'h0, 48'h0},
      '{48'h0, 48'h0, 48'h0, 48'h0},
      '{48'h0, 48'h0, 48'h0, 48'h0},
      '{48'h1000_0000, 48'h1000_0000, 48'hf000_0000_0000, 48'hf000_0000_0000},
      '{48'h0, 48'h0, 48'h0, 48'h0}
    };
    foreach (pat[i]) send_step(pat[i][0], pat[i][1], pat[i][2], pat[i][3]);
    in_ch.valid <= 1'b0;
    drain();

    // zero step: state must hold
    write_reg(lrk_pkg::REG_TIME_STEP, 64'd0);
    for (int i = 0; i < 4; i++) send_step(pick_noise(), pick_noise(), pick_noise(), pick_noise());
    in_ch.valid <= 1'b0;
    drain();

    // step above one, taken as written
    write_reg(lrk_pkg::REG_TIME_STEP, 64'h1ff_ffff);
    for (int i = 0; i < 4; i++) send_step(pick_noise(), pick_noise(), pick_noise(), pick_noise());
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: load_config(32'hffff_ffff, 32'h0, 40'h7f_ffff_ffff, 40'h80_0000_0000, 25'h100_0000);
        1: load_config(32'h0, 32'hffff_ffff, 40'h80_0000_0000, 40'h7f_ffff_ffff, 25'd1);
        default: load_config($urandom_range(0, 32'h1000_0000), $urandom_range(0, 32'h0400_0000),
                             40'($signed($urandom)), 40'($signed($urandom)),
                             25'($urandom_range(1, 32'h2_0000)));
      endcase
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (random_sent < 350) begin
          send_pct = 24;
          recv_pct = 79;
        end else if (random_sent < 700) begin
          send_pct = 79;
          recv_pct = 24;
        end else begin
          send_pct = 0;
          recv_pct = 0;
        end
        send_step(pick_noise(), pick_noise(), pick_noise(), pick_noise());
        random_sent++;
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("checked %0d RK4 steps over %0d register settings, %0d with saturated radius",
             tracker.steps_checked, RANDOM_PHASES + 3, tracker.saturated_radius);
    $display("mismatches: %0d", tracker.errors);
    if (tracker.errors == 0 && tracker.expected_steps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
